>>> sv/printf_template_checker_assert.svh
// Assertion macros for the checker file of the template checker.
`ifndef PRINTF_TEMPLATE_CHECKER_ASSERT_SVH
`define PRINTF_TEMPLATE_CHECKER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define PTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define PTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/ptc_pkg.sv
// Shared types and constants of the printf template checker.
`default_nettype none

package ptc_pkg;

  localparam int CharWidth  = 8;
  localparam int AccWidth   = 20;
  localparam int CountWidth = 16;
  localparam int LenWidth   = 16;

  localparam logic [AccWidth-1:0]   AccMax   = '1;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [CharWidth-1:0] CharPercent = 8'h25;  // '%'
  localparam logic [CharWidth-1:0] CharDot     = 8'h2E;  // '.'
  localparam logic [CharWidth-1:0] CharZero    = 8'h30;  // '0'
  localparam logic [CharWidth-1:0] CharNine    = 8'h39;  // '9'
  localparam logic [CharWidth-1:0] CharLowerU  = 8'h75;  // 'u'
  localparam logic [CharWidth-1:0] CharLowerD  = 8'h64;  // 'd'

  localparam logic [AccWidth-1:0] BaseLenUnsigned = 20'd10;
  localparam logic [AccWidth-1:0] BaseLenSigned   = 20'd11;

  // Configuration register indexes.
  localparam logic CfgSignedMode = 1'b0;
  localparam logic CfgMaxLength  = 1'b1;

  localparam logic [LenWidth-1:0] MaxLengthReset = 16'd32;

  typedef enum logic [2:0] {
    PS_START,
    PS_PERCENT,
    PS_WIDTH,
    PS_PRECISION,
    PS_ERROR
  } parse_state_t;

  // One template character as held in the input stage.
  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 is_last;
  } char_beat_t;

endpackage

`default_nettype wire

>>> sv/ptc_in_stage.sv
// Input register stage of the template checker.
`default_nettype none

module ptc_in_stage
  import ptc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  input  wire char_beat_t s_beat,
  input  wire logic       take,
  output logic            held_valid,
  output char_beat_t      held_beat
);

  // A new beat can enter when the stage is empty or the held one leaves in the same cycle.
  assign s_ready = !held_valid || take;

  // Valid flag of the held beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  // Payload; no reset needed.
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held_beat <= s_beat;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptc_parser.sv
// Template parser state, accumulators and the end-of-template verdict.
`default_nettype none

module ptc_parser
  import ptc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire char_beat_t          beat,
  input  wire logic                signed_mode,
  input  wire logic [LenWidth-1:0] max_length,
  output logic                     verdict
);

  parse_state_t            parse_state, parse_state_next;
  logic                    conversion_seen, conversion_seen_next;
  logic [AccWidth-1:0]     field_width, field_width_next;
  logic [AccWidth-1:0]     field_precision, field_precision_next;
  logic [CountWidth-1:0]   literal_count, literal_count_next;

  logic [CharWidth-1:0]    letter;
  logic                    is_digit;
  logic [3:0]              digit_val;
  logic [AccWidth-1:0]     acc_src;
  logic [AccWidth+3:0]     acc_sum;
  logic [AccWidth-1:0]     acc_sat;
  logic [CountWidth-1:0]   count_inc;
  logic [AccWidth-1:0]     base_len;
  logic [AccWidth-1:0]     len_max;
  logic [AccWidth:0]       len_total;

  assign letter    = signed_mode ? CharLowerD : CharLowerU;
  assign digit_val = 4'(beat.character - CharZero);
  assign count_inc = (literal_count == CountMax) ? literal_count : literal_count + 1'b1;

  always_comb begin
    is_digit = beat.character inside {[CharZero:CharNine]};
  end

  // One shared decimal accumulator step: acc * 10 + digit, saturated.
  assign acc_src = (parse_state == PS_PRECISION) ? field_precision : field_width;
  assign acc_sum = {acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + {20'd0, digit_val};
  assign acc_sat = (acc_sum[AccWidth+3:AccWidth] != 4'd0) ? AccMax : acc_sum[AccWidth-1:0];

  // Next-state logic for one character.
  always_comb begin
    parse_state_next     = parse_state;
    conversion_seen_next = conversion_seen;
    field_width_next     = field_width;
    field_precision_next = field_precision;
    literal_count_next   = literal_count;
    case (parse_state)
      PS_START: begin
        if (beat.character == CharPercent) begin
          parse_state_next = PS_PERCENT;
        end else begin
          literal_count_next = count_inc;
        end
      end
      PS_PERCENT: begin
        if (beat.character == CharPercent) begin
          literal_count_next = count_inc;
          parse_state_next   = PS_START;
        end else if (is_digit) begin
          field_width_next = {16'd0, digit_val};
          parse_state_next = PS_WIDTH;
        end else if (beat.character == CharDot) begin
          parse_state_next = PS_PRECISION;
        end else if (beat.character == letter) begin
          conversion_seen_next = 1'b1;
          parse_state_next     = conversion_seen ? PS_ERROR : PS_START;
        end else begin
          parse_state_next = PS_ERROR;
        end
      end
      PS_WIDTH: begin
        if (is_digit) begin
          field_width_next = acc_sat;
          if (acc_sat >= {4'd0, max_length}) begin
            parse_state_next = PS_ERROR;
          end
        end else if (beat.character == CharDot) begin
          parse_state_next = PS_PRECISION;
        end else if (beat.character == letter) begin
          conversion_seen_next = 1'b1;
          parse_state_next     = conversion_seen ? PS_ERROR : PS_START;
        end else begin
          parse_state_next = PS_ERROR;
        end
      end
      PS_PRECISION: begin
        if (is_digit) begin
          field_precision_next = acc_sat;
          if (acc_sat >= {4'd0, max_length}) begin
            parse_state_next = PS_ERROR;
          end
        end else if (beat.character == letter) begin
          conversion_seen_next = 1'b1;
          parse_state_next     = conversion_seen ? PS_ERROR : PS_START;
        end else begin
          parse_state_next = PS_ERROR;
        end
      end
      default: begin
        parse_state_next = PS_ERROR;
      end
    endcase
  end

  // Verdict. A character that lands in the start state never touches the
  // width or precision, so the stored values are the final ones.
  assign base_len  = signed_mode ? BaseLenSigned : BaseLenUnsigned;
  always_comb begin
    len_max = base_len;
    if (field_width > len_max) begin
      len_max = field_width;
    end
    if (field_precision > len_max) begin
      len_max = field_precision;
    end
  end
  assign len_total = {1'b0, len_max} + {5'd0, literal_count_next};
  assign verdict   = (parse_state_next == PS_START) && conversion_seen_next &&
                     (len_total < {5'd0, max_length});

  // Parser registers; the last character of a template clears them all.
  always_ff @(posedge clk) begin
    if (rst || (step && beat.is_last)) begin
      parse_state     <= PS_START;
      conversion_seen <= 1'b0;
      field_width     <= '0;
      field_precision <= '0;
      literal_count   <= '0;
    end else if (step) begin
      parse_state     <= parse_state_next;
      conversion_seen <= conversion_seen_next;
      field_width     <= field_width_next;
      field_precision <= field_precision_next;
      literal_count   <= literal_count_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/printf_template_checker.sv
// Top level of the printf template checker.
//
//  Channel  Handshake                      Carries
//  s_axis   s_axis_tvalid/s_axis_tready    tdata: character; tlast: is_last
//  m_axis   m_axis_tvalid/m_axis_tready    tdata: template_ok (bit 0)
//  cfg      cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One character is taken every cycle, except while a last beat waits on a
// stalled result. A character is parsed while it sits in the input register,
// and the verdict of a last beat enters the result register as it leaves.
// A stalled result holds back only a last beat and the input behind it.
// Synchronous reset clears the parser and restores signed_mode 0 and
// max_length 32. The configuration port is always ready.
`default_nettype none

module printf_template_checker
  import ptc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] character
  input  wire logic                 s_axis_tlast,   // is_last
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [0] template_ok, [7:1] zero
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [LenWidth-1:0]  cfg_data
);

  logic                signed_mode;
  logic [LenWidth-1:0] max_length;
  char_beat_t          in_beat;
  char_beat_t          held_beat;
  logic                held_valid;
  logic                take;
  logic                verdict;
  logic                out_free;
  logic                template_ok;

  assign in_beat = '{character: s_axis_tdata, is_last: s_axis_tlast};

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
      max_length  <= MaxLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgSignedMode: signed_mode <= cfg_data[0];
        CfgMaxLength:  max_length  <= cfg_data;
        default:       ;
      endcase
    end
  end

  ptc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_beat     (in_beat),
    .take       (take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  // A last beat needs room in the result register; others never wait.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign take     = held_valid && (!held_beat.is_last || out_free);

  ptc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .beat        (held_beat),
    .signed_mode (signed_mode),
    .max_length  (max_length),
    .verdict     (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take && held_beat.is_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_beat.is_last) begin
      template_ok <= verdict;
    end
  end

  assign m_axis_tdata = {7'd0, template_ok};

endmodule

`default_nettype wire

>>> sv/ptc_checker.sv
// Port-level checks of the template checker and their binding.
`default_nettype none
`include "printf_template_checker_assert.svh"

module ptc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic s_axis_tlast,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // A rising verdict was set in the cycle after its last beat was accepted.
  `PTC_ASSERT(a_verdict_follows_last, clk, rst, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "verdict without a preceding last beat")

  // The padding bits of a result beat are zero.
  `PTC_ASSERT(a_result_padding, clk, rst, m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0), "nonzero padding in result beat")

  // A stalled result stays up with unchanged data.
  `PTC_ASSERT(a_result_holds, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result beat changed")

  // Reset leaves no result pending.
  `PTC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind printf_template_checker ptc_checker u_ptc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Stream testbench for the printf template checker, with its own parser model.
module testbench;
  import ptc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] character
  logic                s_axis_tlast = 1'b0; // is_last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [0] template_ok, [7:1] zero
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CfgSignedMode;
  logic [LenWidth-1:0] cfg_data = '0;

  printf_template_checker uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Characters waiting to be sent and verdicts waiting to come back.
  char_beat_t  char_beats[$];
  logic [7:0]  verdicts_due[$];
  logic [7:0]  tmpl[$];
  logic        char_taken = 1'b0;
  bit          quiet = 1'b0;

  // Generator's view of the registers.
  bit          cur_signed = 1'b0;
  int unsigned cur_max = 32'(MaxLengthReset);

  // Parser model state and its copy of the registers.
  bit                   m_signed = 1'b0;
  logic [LenWidth-1:0]  m_max = MaxLengthReset;
  parse_state_t         m_state = PS_START;
  bit                   m_conv = 1'b0;
  logic [AccWidth-1:0]  m_width = '0;
  logic [AccWidth-1:0]  m_prec = '0;
  logic [CountWidth-1:0] m_lits = '0;

  int errors = 0;
  int n_chars = 0;
  int n_templates = 0;
  int n_checked = 0;
  int n_valid = 0;
  int n_settings = 0;

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Decimal accumulation with saturation at the accumulator limit.
  function automatic logic [AccWidth-1:0] acc_next(logic [AccWidth-1:0] acc, logic [7:0] c);
    int unsigned v;
    v = 32'(acc) * 10 + 32'(c - CharZero);
    return (v > 32'(AccMax)) ? AccMax : AccWidth'(v);
  endfunction

  // A conversion letter: the first one closes the spec, a second is an error.
  task automatic end_conversion();
    if (m_conv) begin
      m_state = PS_ERROR;
    end else begin
      m_conv = 1'b1;
      m_state = PS_START;
    end
  endtask

  // Advance the parser by one character; on the last one, give the verdict.
  task automatic scan_char(input logic [7:0] c, input logic last,
                           output bit has_verdict, output bit ok);
    logic [7:0]  letter;
    bit          is_digit;
    int unsigned len;
    letter = m_signed ? CharLowerD : CharLowerU;
    is_digit = (c >= CharZero) && (c <= CharNine);
    has_verdict = 1'b0;
    ok = 1'b0;
    case (m_state)
      PS_START: begin
        if (c == CharPercent) m_state = PS_PERCENT;
        else if (m_lits != CountMax) m_lits++;
      end
      PS_PERCENT: begin
        if (c == CharPercent) begin
          if (m_lits != CountMax) m_lits++;
          m_state = PS_START;
        end else if (is_digit) begin
          // The first width digit is not compared with max_length.
          m_width = AccWidth'(c - CharZero);
          m_state = PS_WIDTH;
        end else if (c == CharDot) begin
          m_state = PS_PRECISION;
        end else if (c == letter) begin
          end_conversion();
        end else begin
          m_state = PS_ERROR;
        end
      end
      PS_WIDTH: begin
        if (is_digit) begin
          m_width = acc_next(m_width, c);
          if (m_width >= AccWidth'(m_max)) m_state = PS_ERROR;
        end else if (c == CharDot) begin
          m_state = PS_PRECISION;
        end else if (c == letter) begin
          end_conversion();
        end else begin
          m_state = PS_ERROR;
        end
      end
      PS_PRECISION: begin
        if (is_digit) begin
          m_prec = acc_next(m_prec, c);
          if (m_prec >= AccWidth'(m_max)) m_state = PS_ERROR;
        end else if (c == letter) begin
          end_conversion();
        end else begin
          m_state = PS_ERROR;
        end
      end
      default: m_state = PS_ERROR;
    endcase
    if (last) begin
      has_verdict = 1'b1;
      if (m_state == PS_START && m_conv) begin
        len = 32'(m_signed ? BaseLenSigned : BaseLenUnsigned);
        if (len < 32'(m_width)) len = 32'(m_width);
        if (len < 32'(m_prec)) len = 32'(m_prec);
        len += 32'(m_lits);
        ok = len < 32'(m_max);
      end
      m_state = PS_START;
      m_conv = 1'b0;
      m_width = '0;
      m_prec = '0;
      m_lits = '0;
    end
  endtask

  // Monitor: track register writes, predict on each character beat and
  // check each verdict beat against the oldest prediction.
  always @(posedge clk) begin
    bit         has_verdict;
    bit         ok;
    logic [7:0] want;
    if (rst) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgSignedMode) m_signed = cfg_data[0];
        else m_max = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_chars++;
        scan_char(s_axis_tdata, s_axis_tlast, has_verdict, ok);
        if (has_verdict) verdicts_due.push_back({7'b0, ok});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: verdict beat with no template finished, got %0d",
                   $time, m_axis_tdata);
        end else begin
          want = verdicts_due.pop_front();
          n_checked++;
          if (want[0]) n_valid++;
          if (m_axis_tdata !== want) begin
            errors++;
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, want, m_axis_tdata);
          end
        end
      end
    end
  end

  // Character driver: one beat at a time from the queue, with random gaps.
  always @(negedge clk) begin
    char_beat_t beat;
    int         gap_left;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_axis_tvalid || char_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (char_beats.size() > 0) begin
        beat = char_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat.character;
        s_axis_tlast <= beat.is_last;
        gap_left = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Verdict receiver: random stalls.
  always @(negedge clk) begin
    int stall_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Queue the template under construction as character beats.
  task automatic send_template();
    char_beat_t beat;
    for (int i = 0; i < tmpl.size(); i++) begin
      beat.character = tmpl[i];
      beat.is_last = (i == tmpl.size() - 1);
      char_beats.push_back(beat);
    end
    n_templates++;
    tmpl.delete();
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) tmpl.push_back(s[i]);
  endtask

  task automatic put_number(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CharZero + 8'(v % 10));
      v /= 10;
    end while (v != 0);
    foreach (digits[i]) tmpl.push_back(digits[i]);
  endtask

  // Literal text; a doubled percent now and then counts as one literal.
  task automatic put_literals(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        tmpl.push_back(CharPercent);
        tmpl.push_back(CharPercent);
      end else begin
        c = 8'($urandom_range(0, 255));
        tmpl.push_back(c == CharPercent ? CharDot : c);
      end
    end
  endtask

  // Width or precision value, clustered around the length limit.
  function automatic int unsigned field_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 9);
      2: return (cur_max > 2) ? cur_max - 2 + $urandom_range(0, 4) : $urandom_range(0, 4);
      3, 4: return $urandom_range(0, cur_max);
      default: return $urandom_range(0, 999999);
    endcase
  endfunction

  // A conversion spec, usually with the configured letter.
  task automatic put_spec();
    tmpl.push_back(CharPercent);
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 7) == 0) tmpl.push_back(CharZero);
      put_number(field_value());
    end
    if ($urandom_range(0, 1) == 0) begin
      tmpl.push_back(CharDot);
      if ($urandom_range(0, 3) != 0) put_number(field_value());
    end
    if ($urandom_range(0, 19) == 0) tmpl.push_back(cur_signed ? CharLowerU : CharLowerD);
    else tmpl.push_back(cur_signed ? CharLowerD : CharLowerU);
  endtask

  // One random template: mostly well formed, the rest broken or noise.
  task automatic make_template();
    int lim;
    int n_lit;
    int pre;
    int r;
    lim = (cur_max < 30) ? cur_max : 30;
    n_lit = $urandom_range(0, lim);
    pre = $urandom_range(0, n_lit);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      put_literals(pre);
      put_spec();
      put_literals(n_lit - pre);
    end else if (r < 65) begin
      put_literals(n_lit + 1);
    end else if (r < 75) begin
      put_literals(pre);
      put_spec();
      put_literals(n_lit - pre);
      put_spec();
    end else if (r < 85) begin
      // Template cut off inside a conversion spec.
      put_literals(pre);
      tmpl.push_back(CharPercent);
      if ($urandom_range(0, 1) == 0) put_number(field_value());
      if ($urandom_range(0, 1) == 0) tmpl.push_back(CharDot);
    end else begin
      repeat ($urandom_range(1, 10)) tmpl.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [LenWidth-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every verdict is back, then let the pipeline empty.
  task automatic wait_idle();
    while (char_beats.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus: directed templates under reset settings, then random phases.
  initial begin
    bit          set_signed[10];
    int unsigned set_max[10];
    int          start;
    set_signed = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    set_max = '{32, 0, 65535, 1, 12, 11, 20,
                $urandom_range(13, 80), $urandom_range(13, 80), 32};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, both letters, doubled percent, second
    // conversion, oversize width and precision, bad letter, bare percent.
    tmpl.push_back(8'h00);
    put_text("%u");
    send_template();
    put_text("%d");
    send_template();
    put_text("%%%u");
    send_template();
    put_text("%u%u");
    send_template();
    put_text("%99u");
    send_template();
    put_text("%.40u");
    send_template();
    tmpl.push_back(8'hFF);
    send_template();
    put_text("%x");
    send_template();
    put_text("%");
    send_template();
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 10; p++) begin
      cur_signed = set_signed[p];
      cur_max = set_max[p];
      write_reg(CfgSignedMode, LenWidth'(cur_signed));
      write_reg(CfgMaxLength, LenWidth'(cur_max));
      n_settings++;
      quiet = (p % 4 == 3);
      start = char_beats.size();
      while (char_beats.size() - start < 85) begin
        make_template();
        send_template();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
    end
    $display("Covered %0d characters in %0d templates across %0d register settings.",
             n_chars, n_templates, n_settings + 1);
    $display("Compared %0d verdicts, %0d of them for valid templates.", n_checked, n_valid);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ptc_pkg.sv
sv/ptc_in_stage.sv
sv/ptc_parser.sv
sv/printf_template_checker.sv
sv/ptc_checker.sv
tb/sv/testbench.sv
